### hw/rtl/cmft_pkg.sv
// ----------------------------------------------------------------------------
// cmft_pkg: shared types and constants
// Codes and sideband types for the cube map face and texel address pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package cmft_pkg;

   // face code is {axis, negative}
   localparam int FACE_W = 3;
   localparam int AXIS_W = 2;

   localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
   localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
   localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

   // configuration registers
   localparam int CFG_W      = 13;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic REG_FACE_WIDTH  = 1'b0;
   localparam logic REG_FACE_HEIGHT = 1'b1;

   localparam logic [CFG_W-1:0] FACE_SIZE_RESET = 13'd512;

   // per-word sideband carried down the pipeline
   typedef struct packed {
      logic [FACE_W-1:0] face;
      logic              degenerate;
   } face_info_type;

endpackage

`default_nettype wire

### hw/rtl/cmft_csr.sv
// ----------------------------------------------------------------------------
// cmft_csr: configuration registers
// Face width/height registers on an APB-style port, plus clamped sizes.
// ----------------------------------------------------------------------------
`default_nettype none

module cmft_csr
   import cmft_pkg::*;
#(
   parameter int MAX_FACE_SIZE = 4096,
   parameter int SIZE_W        = 13
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output logic      [SIZE_W-1:0]     eff_width,
   output logic      [SIZE_W-1:0]     eff_height
);

   logic [CFG_W-1:0]  width_ff, width_in;
   logic [CFG_W-1:0]  height_ff, height_in;
   logic [SIZE_W-1:0] eff_width_ff, eff_width_in;
   logic [SIZE_W-1:0] eff_height_ff, eff_height_in;
   logic              wr_en;
   logic              reg_sel;

   // word offset picks the register; byte offset bits are don't-care
   assign reg_sel = paddr[2];
   assign wr_en   = psel & penable & pwrite & pready;
   assign pready  = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_FACE_WIDTH:  width_in  = pwdata[CFG_W-1:0];
            REG_FACE_HEIGHT: height_in = pwdata[CFG_W-1:0];
            default:         width_in  = width_ff;
         endcase
      end
   end

   // size zero acts as one, anything past the max acts as the max
   always_comb begin
      if (width_ff == '0) begin
         eff_width_in = SIZE_W'(1);
      end else if (int'(width_ff) > MAX_FACE_SIZE) begin
         eff_width_in = SIZE_W'(MAX_FACE_SIZE);
      end else begin
         eff_width_in = SIZE_W'(width_ff);
      end
      if (height_ff == '0) begin
         eff_height_in = SIZE_W'(1);
      end else if (int'(height_ff) > MAX_FACE_SIZE) begin
         eff_height_in = SIZE_W'(MAX_FACE_SIZE);
      end else begin
         eff_height_in = SIZE_W'(height_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= FACE_SIZE_RESET;
         height_ff     <= FACE_SIZE_RESET;
         eff_width_ff  <= SIZE_W'(FACE_SIZE_RESET);
         eff_height_ff <= SIZE_W'(FACE_SIZE_RESET);
      end else begin
         width_ff      <= width_in;
         height_ff     <= height_in;
         eff_width_ff  <= eff_width_in;
         eff_height_ff <= eff_height_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_FACE_WIDTH:  prdata = CSR_DATA_W'(width_ff);
         REG_FACE_HEIGHT: prdata = CSR_DATA_W'(height_ff);
         default:         prdata = '0;
      endcase
   end

   assign eff_width  = eff_width_ff;
   assign eff_height = eff_height_ff;

endmodule

`default_nettype wire

### hw/rtl/cmft_face_select.sv
// ----------------------------------------------------------------------------
// cmft_face_select: major axis and numerator stages
// Three stages: mirror and magnitude, axis pick, in-face numerators.
// ----------------------------------------------------------------------------
`default_nettype none

module cmft_face_select
   import cmft_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         en,
   input  wire logic                         in_valid,
   input  wire logic signed [COORD_BITS-1:0] dir_x,
   input  wire logic signed [COORD_BITS-1:0] dir_y,
   input  wire logic signed [COORD_BITS-1:0] dir_z,
   output logic                              out_valid,
   output face_info_type                     out_info,
   output logic             [COORD_BITS:0]   col_num,
   output logic             [COORD_BITS:0]   row_num,
   output logic             [COORD_BITS:0]   den
);

   localparam int CB = COORD_BITS;

   // stage A: mirrored vector and magnitudes
   logic signed [CB:0]   l_in [3];
   logic        [CB-1:0] mag_in [3];
   logic signed [CB:0]   a_l_ff [3];
   logic        [CB-1:0] a_mag_ff [3];
   logic                 a_valid_ff;

   assign l_in[0] = -$signed({dir_x[CB-1], dir_x});
   assign l_in[1] = $signed({dir_y[CB-1], dir_y});
   assign l_in[2] = $signed({dir_z[CB-1], dir_z});

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_in[i] = l_in[i][CB] ? CB'(-l_in[i]) : l_in[i][CB-1:0];
      end
   end

   // stage B: major axis, strict compare so ties keep the lower axis
   logic              sel_y;
   logic [CB-1:0]     mag_xy;
   logic              sel_z;
   logic [AXIS_W-1:0] axis_in;
   logic [CB-1:0]     m_in;
   logic              pos_in;
   face_info_type     info_in;

   logic signed [CB:0]   b_l_ff [3];
   logic [AXIS_W-1:0]    b_axis_ff;
   logic [CB-1:0]        b_m_ff;
   logic                 b_pos_ff;
   face_info_type        b_info_ff;
   logic                 b_valid_ff;

   always_comb begin
      sel_y  = a_mag_ff[1] > a_mag_ff[0];
      mag_xy = sel_y ? a_mag_ff[1] : a_mag_ff[0];
      sel_z  = a_mag_ff[2] > mag_xy;
      if (sel_z) begin
         axis_in = AXIS_Z;
         m_in    = a_mag_ff[2];
         pos_in  = ~a_l_ff[2][CB] & (a_mag_ff[2] != '0);
      end else if (sel_y) begin
         axis_in = AXIS_Y;
         m_in    = a_mag_ff[1];
         pos_in  = ~a_l_ff[1][CB] & (a_mag_ff[1] != '0);
      end else begin
         axis_in = AXIS_X;
         m_in    = a_mag_ff[0];
         pos_in  = ~a_l_ff[0][CB] & (a_mag_ff[0] != '0);
      end
      // zero vector lands on axis x, not positive: face 1
      info_in.face       = {axis_in, ~pos_in};
      info_in.degenerate = (m_in == '0);
   end

   // stage C: numerators in [0, 2m]
   logic signed [CB+1:0] m_s;
   logic signed [CB+1:0] l_e [3];
   logic signed [CB+1:0] col_s;
   logic signed [CB+1:0] row_s;

   logic [CB:0]   c_col_ff;
   logic [CB:0]   c_row_ff;
   logic [CB:0]   c_den_ff;
   face_info_type c_info_ff;
   logic          c_valid_ff;

   always_comb begin
      m_s = $signed({2'b00, b_m_ff});
      for (int i = 0; i < 3; i++) begin
         l_e[i] = $signed({b_l_ff[i][CB], b_l_ff[i]});
      end
      case (b_axis_ff)
         AXIS_X: begin
            row_s = m_s + l_e[1];
            col_s = b_pos_ff ? m_s - l_e[2] : m_s + l_e[2];
         end
         AXIS_Y: begin
            col_s = m_s + l_e[0];
            row_s = b_pos_ff ? m_s - l_e[2] : m_s + l_e[2];
         end
         AXIS_Z: begin
            row_s = m_s + l_e[1];
            col_s = b_pos_ff ? m_s + l_e[0] : m_s - l_e[0];
         end
         default: begin
            row_s = '0;
            col_s = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            a_l_ff[i]   <= l_in[i];
            a_mag_ff[i] <= mag_in[i];
            b_l_ff[i]   <= a_l_ff[i];
         end
         b_axis_ff <= axis_in;
         b_m_ff    <= m_in;
         b_pos_ff  <= pos_in;
         b_info_ff <= info_in;
         c_col_ff  <= col_s[CB:0];
         c_row_ff  <= row_s[CB:0];
         c_den_ff  <= {b_m_ff, 1'b0};
         c_info_ff <= b_info_ff;
      end
   end

   assign out_valid = c_valid_ff;
   assign out_info  = c_info_ff;
   assign col_num   = c_col_ff;
   assign row_num   = c_row_ff;
   assign den       = c_den_ff;

endmodule

`default_nettype wire

### hw/rtl/cmft_texel_div.sv
// ----------------------------------------------------------------------------
// cmft_texel_div: pipelined scale and divide
// floor(size * num / den): one multiply stage, then one quotient bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cmft_texel_div #(
   parameter int NUM_W  = 17,
   parameter int SIZE_W = 13
) (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire logic [NUM_W-1:0]  num,
   input  wire logic [NUM_W-1:0]  den,
   input  wire logic [SIZE_W-1:0] size,
   output logic      [SIZE_W-1:0] quot
);

   localparam int PW = SIZE_W + NUM_W;

   // index 0 is the product stage, index k+1 holds k+1 quotient bits
   logic [PW-1:0]     rem_ff [SIZE_W+1];
   logic [NUM_W-1:0]  dd_ff  [SIZE_W+1];
   logic [SIZE_W-1:0] q_ff   [SIZE_W+1];

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= PW'(size) * PW'(num);
         dd_ff[0]  <= den;
         q_ff[0]   <= '0;
      end
   end

   // quotient is at most size, so SIZE_W restoring steps cover it
   for (genvar k = 0; k < SIZE_W; k++) begin : g_step
      logic [PW-1:0] dsh;
      logic          ge;

      assign dsh = {{SIZE_W{1'b0}}, dd_ff[k]} << (SIZE_W - 1 - k);
      assign ge  = rem_ff[k] >= dsh;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= ge ? rem_ff[k] - dsh : rem_ff[k];
            dd_ff[k+1]  <= dd_ff[k];
            q_ff[k+1]   <= {q_ff[k][SIZE_W-2:0], ge};
         end
      end
   end

   assign quot = q_ff[SIZE_W];

endmodule

`default_nettype wire

### hw/rtl/cube_map_face_texel_address.sv
// ----------------------------------------------------------------------------
// cube_map_face_texel_address: cube map face pick and texel address
// Maps a signed lookup direction to a cube face and a clamped texel.
// ----------------------------------------------------------------------------
// Takes one direction word per clock and returns one result word per clock
// whenever rsp_tready is high. The pipeline holds three face-select stages,
// one size*numerator multiply, one restoring divide stage per quotient bit
// and the output register; the divide pipeline length sets its depth.
// The whole pipeline advances on one enable, so a stall holds every stage and
// req_tready drops only while a finished result sits unread.
// The x component is mirrored before the major axis is picked; on magnitude
// ties x wins over y and y over z. An all-zero direction returns face 1,
// texel 0/0 and raises the degenerate flag in rsp_tuser. Face sizes of zero
// read as one, sizes past MAX_FACE_SIZE read as MAX_FACE_SIZE. The face size
// registers should be written only while no word is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module cube_map_face_texel_address
   import cmft_pkg::*;
#(
   parameter int COORD_BITS    = 16,
   parameter int MAX_FACE_SIZE = 4096
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // dir_x, dir_y, dir_z (COORD_BITS each, signed), zero padded to bytes
   input  wire logic [((3*COORD_BITS+7)/8)*8-1:0] req_tdata,

   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // face (3), texel_col, texel_row, zero padded to bytes
   output logic [((FACE_W+2*$clog2(MAX_FACE_SIZE)+7)/8)*8-1:0] rsp_tdata,
   // degenerate
   output logic                       rsp_tuser,

   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   localparam int SIZE_W  = $clog2(MAX_FACE_SIZE + 1);
   localparam int TEXEL_W = $clog2(MAX_FACE_SIZE);
   localparam int NUM_W   = COORD_BITS + 1;
   localparam int DIV_LAT = SIZE_W + 1;
   localparam int OUT_W   = ((FACE_W + 2*TEXEL_W + 7) / 8) * 8;

   logic              en;
   logic [SIZE_W-1:0] eff_width;
   logic [SIZE_W-1:0] eff_height;

   // face select outputs
   logic              fs_valid;
   face_info_type     fs_info;
   logic [NUM_W-1:0]  fs_col_num;
   logic [NUM_W-1:0]  fs_row_num;
   logic [NUM_W-1:0]  fs_den;

   logic [SIZE_W-1:0] col_quot;
   logic [SIZE_W-1:0] row_quot;

   // valid and sideband ride alongside the divide pipeline
   logic              chain_valid_ff [DIV_LAT];
   face_info_type     chain_info_ff  [DIV_LAT];

   logic                out_valid_ff;
   logic [FACE_W-1:0]   out_face_ff,  out_face_in;
   logic [TEXEL_W-1:0]  out_col_ff,   out_col_in;
   logic [TEXEL_W-1:0]  out_row_ff,   out_row_in;
   logic                out_degen_ff, out_degen_in;
   face_info_type       tail_info;

   // pipeline moves when the output register is empty or being drained
   assign en         = ~out_valid_ff | rsp_tready;
   assign req_tready = en;

   cmft_csr #(
      .MAX_FACE_SIZE (MAX_FACE_SIZE),
      .SIZE_W        (SIZE_W)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (csr_psel),
      .penable    (csr_penable),
      .pwrite     (csr_pwrite),
      .paddr      (csr_paddr),
      .pwdata     (csr_pwdata),
      .prdata     (csr_prdata),
      .pready     (csr_pready),
      .eff_width  (eff_width),
      .eff_height (eff_height)
   );

   cmft_face_select #(
      .COORD_BITS (COORD_BITS)
   ) u_face_select (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .dir_x     ($signed(req_tdata[COORD_BITS-1:0])),
      .dir_y     ($signed(req_tdata[2*COORD_BITS-1:COORD_BITS])),
      .dir_z     ($signed(req_tdata[3*COORD_BITS-1:2*COORD_BITS])),
      .out_valid (fs_valid),
      .out_info  (fs_info),
      .col_num   (fs_col_num),
      .row_num   (fs_row_num),
      .den       (fs_den)
   );

   cmft_texel_div #(
      .NUM_W  (NUM_W),
      .SIZE_W (SIZE_W)
   ) u_col_div (
      .clock (clock),
      .en    (en),
      .num   (fs_col_num),
      .den   (fs_den),
      .size  (eff_width),
      .quot  (col_quot)
   );

   cmft_texel_div #(
      .NUM_W  (NUM_W),
      .SIZE_W (SIZE_W)
   ) u_row_div (
      .clock (clock),
      .en    (en),
      .num   (fs_row_num),
      .den   (fs_den),
      .size  (eff_height),
      .quot  (row_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_LAT; k++) begin
            chain_valid_ff[k] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else if (en) begin
         chain_valid_ff[0] <= fs_valid;
         for (int k = 1; k < DIV_LAT; k++) begin
            chain_valid_ff[k] <= chain_valid_ff[k-1];
         end
         out_valid_ff <= chain_valid_ff[DIV_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         chain_info_ff[0] <= fs_info;
         for (int k = 1; k < DIV_LAT; k++) begin
            chain_info_ff[k] <= chain_info_ff[k-1];
         end
      end
   end

   // quotient equals size only when the numerator hits 2m: clamp to size-1
   assign tail_info = chain_info_ff[DIV_LAT-1];

   always_comb begin
      out_face_in  = tail_info.face;
      out_degen_in = tail_info.degenerate;
      if (tail_info.degenerate) begin
         out_col_in = '0;
         out_row_in = '0;
      end else begin
         out_col_in = (col_quot >= eff_width) ? TEXEL_W'(eff_width - 1'b1)
                                              : col_quot[TEXEL_W-1:0];
         out_row_in = (row_quot >= eff_height) ? TEXEL_W'(eff_height - 1'b1)
                                               : row_quot[TEXEL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_face_ff  <= out_face_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         out_degen_ff <= out_degen_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = OUT_W'({out_row_ff, out_col_ff, out_face_ff});
   assign rsp_tuser  = out_degen_ff;

endmodule

`default_nettype wire

### test/cube_map_face_texel_address_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cube_map_face_texel_address_tb: self-checking bench for the cube face mapper
// Streams lookup directions through the block under several face sizes and
// checks each face, texel and degenerate flag against an exact integer model.
// ----------------------------------------------------------------------------

module cube_map_face_texel_address_tb;
   import cmft_pkg::*;

   localparam int FACE_SIZE_MAX   = 4096;
   localparam int PIPE_LATENCY    = 18;
   localparam int STALL_LIMIT     = 1000;   // cycles with no word moving
   localparam int WORDS_PER_PHASE = 118;
   localparam int FIXED_PHASES    = 6;

   // face sizes per phase; zero and sizes past the maximum are legal codes
   localparam int PHASE_WIDTH  [FIXED_PHASES] = '{1, 4096, 0, 4097, 3, 8191};
   localparam int PHASE_HEIGHT [FIXED_PHASES] = '{1, 4096, 8191, 2, 4095, 0};

   // -------------------------------------------------------------------------
   // Expected-texel store: tracks face sizes, predicts each direction word,
   // compares result words in order.
   // -------------------------------------------------------------------------
   class texel_scoreboard;
      typedef struct {
         logic [2:0]  face;
         logic [11:0] col;
         logic [11:0] row;
         logic        degenerate;
      } texel_word_type;

      texel_word_type expected_q[$];
      logic [12:0] face_width;
      logic [12:0] face_height;
      int          errors;

      function new();
         face_width  = FACE_SIZE_RESET;
         face_height = FACE_SIZE_RESET;
         errors      = 0;
      endfunction

      function void set_face_size(logic reg_sel, logic [31:0] value);
         if (reg_sel == REG_FACE_WIDTH) begin
            face_width = value[12:0];
         end else begin
            face_height = value[12:0];
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // size zero reads as one, oversize reads as the maximum
      function longint usable_size(logic [12:0] s);
         if (s == 0) return 1;
         if (s > FACE_SIZE_MAX) return FACE_SIZE_MAX;
         return longint'(s);
      endfunction

      function longint magnitude(longint a);
         return (a < 0) ? -a : a;
      endfunction

      // floor(size * num / den), clamped to the last texel
      function longint scaled_texel(longint size, longint num, longint den);
         longint t;
         t = (size * num) / den;
         return (t > size - 1) ? size - 1 : t;
      endfunction

      function void note_direction(logic signed [15:0] dx, logic signed [15:0] dy,
                                   logic signed [15:0] dz);
         longint         lv [3];
         logic [1:0]     axis;
         logic           positive;
         longint         m;
         longint         cn;
         longint         rn;
         texel_word_type w;

         // mirror x; widened first so -32768 flips exactly
         lv[0] = -longint'(dx);
         lv[1] = longint'(dy);
         lv[2] = longint'(dz);

         // strict compare: ties stay with the earlier axis
         axis = AXIS_X;
         if (magnitude(lv[1]) > magnitude(lv[axis])) axis = AXIS_Y;
         if (magnitude(lv[2]) > magnitude(lv[axis])) axis = AXIS_Z;

         positive = lv[axis] > 0;
         m        = magnitude(lv[axis]);

         if (m == 0) begin
            w.face       = {AXIS_X, 1'b1};
            w.col        = '0;
            w.row        = '0;
            w.degenerate = 1'b1;
            expected_q   = {expected_q, w};
            return;
         end

         case (axis)
            AXIS_X: begin
               rn = m + lv[1];
               cn = positive ? m - lv[2] : m + lv[2];
            end
            AXIS_Y: begin
               cn = m + lv[0];
               rn = positive ? m - lv[2] : m + lv[2];
            end
            default: begin
               rn = m + lv[1];
               cn = positive ? m + lv[0] : m - lv[0];
            end
         endcase

         w.face       = {axis, ~positive};
         w.col        = 12'(scaled_texel(usable_size(face_width), cn, 2 * m));
         w.row        = 12'(scaled_texel(usable_size(face_height), rn, 2 * m));
         w.degenerate = 1'b0;
         expected_q   = {expected_q, w};
      endfunction

      task report_mismatch(string what);
         $display("[%0t] MISMATCH %s", $time, what);
         errors++;
      endtask

      task check_result(logic [2:0] face, logic [11:0] col, logic [11:0] row,
                        logic degenerate);
         texel_word_type w;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("result face %0d col %0d row %0d with none pending",
                                      face, col, row));
            return;
         end
         w = expected_q.pop_front();
         if (face !== w.face)
            report_mismatch($sformatf("face got %0d want %0d", face, w.face));
         if (col !== w.col)
            report_mismatch($sformatf("texel_col got %0d want %0d", col, w.col));
         if (row !== w.row)
            report_mismatch($sformatf("texel_row got %0d want %0d", row, w.row));
         if (degenerate !== w.degenerate)
            report_mismatch($sformatf("degenerate got %0d want %0d", degenerate,
                                      w.degenerate));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // DUT hookup; every input starts at a known value
   // -------------------------------------------------------------------------
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;

   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   // dir_x [15:0], dir_y [31:16], dir_z [47:32]
   logic [47:0] req_tdata   = '0;

   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   // face [2:0], texel_col [14:3], texel_row [26:15], zero pad [31:27]
   logic [31:0] rsp_tdata;
   // degenerate
   logic        rsp_tuser;

   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   texel_scoreboard board = new();

   // traffic shaping shared by sender and receiver
   int   sent_count = 0;
   int   recv_count = 0;
   logic send_burst = 1'b0;   // sender runs back to back
   logic recv_burst = 1'b0;   // receiver takes every word
   logic rsp_hold   = 1'b0;   // receiver in a long hold-off

   cube_map_face_texel_address dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Sender side
   // -------------------------------------------------------------------------

   // Offers one direction word and returns at the edge where it is taken.
   // valid only drops when a gap is drawn, so back-to-back words keep it high.
   task automatic send_direction(input logic signed [15:0] dx,
                                 input logic signed [15:0] dy,
                                 input logic signed [15:0] dz);
      int gap;
      if (sent_count % 40 == 0) send_burst = ($urandom_range(0, 3) == 0);
      // keep feeding during a hold-off so the pipe backs up to the input
      gap = (send_burst || rsp_hold) ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {dz, dy, dx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_direction(dx, dy, dz);
      sent_count++;
   endtask

   // Random component: full range, tiny values (ties, zeros), mid range,
   // or one of the end points or zero.
   function automatic logic signed [15:0] random_component();
      case ($urandom_range(0, 3))
         0:       return 16'($urandom_range(0, 16'hFFFF));
         1:       return 16'(int'($urandom_range(0, 8)) - 4);
         2:       return 16'(int'($urandom_range(0, 2000)) - 1000);
         default: begin
            case ($urandom_range(0, 3))
               0:       return 16'sh8000;
               1:       return -16'sd32767;
               2:       return 16'sd32767;
               default: return 16'sd0;
            endcase
         end
      endcase
   endfunction

   // APB write of one face size register, then read it back.
   // Upper data bits carry junk that the register must drop.
   task automatic program_face_size(input logic reg_sel, input logic [12:0] value);
      logic [31:0] wdata;
      wdata = {19'($urandom), value};

      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= wdata;
      csr_pwrite  <= 1'b1;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      board.set_face_size(reg_sel, wdata);

      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== {19'd0, value})
         board.report_mismatch($sformatf("readback reg %0d got %0h want %0h", reg_sel,
                                         csr_prdata, value));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // every word yields a result, so an empty store means an empty pipe
   task automatic wait_for_drain();
      while (board.pending() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Main sequence: directed words at reset sizes, then random phases
   // -------------------------------------------------------------------------
   initial begin
      logic signed [15:0] dx;
      logic signed [15:0] dy;
      logic signed [15:0] dz;
      int                 w;
      int                 h;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // zero vector -> degenerate
      send_direction(16'sd0, 16'sd0, 16'sd0);
      // one word per face (x is mirrored)
      send_direction(-16'sd100, 16'sd0, 16'sd0);
      send_direction(16'sd100, 16'sd0, 16'sd0);
      send_direction(16'sd0, 16'sd100, 16'sd0);
      send_direction(16'sd0, -16'sd100, 16'sd0);
      send_direction(16'sd0, 16'sd0, 16'sd100);
      send_direction(16'sd0, 16'sd0, -16'sd100);
      // magnitude ties: x over y, y over z, all three equal
      send_direction(-16'sd50, 16'sd50, 16'sd0);
      send_direction(16'sd0, 16'sd50, -16'sd50);
      send_direction(16'sd7, 16'sd7, 16'sd7);
      // most negative component on each axis, mirror must not wrap
      send_direction(16'sh8000, 16'sd0, 16'sd0);
      send_direction(16'sd0, 16'sh8000, 16'sd0);
      send_direction(16'sd0, 16'sd0, 16'sh8000);
      send_direction(16'sh8000, 16'sh8000, 16'sh8000);
      send_direction(16'sd32767, 16'sd32767, 16'sd32767);
      send_direction(16'sh8000, 16'sd32767, -16'sd32767);
      // numerator at 2m (clamped to last texel) and at zero on x, one off the ends on y and z
      send_direction(-16'sd1000, 16'sd1000, -16'sd1000);
      send_direction(16'sd1000, -16'sd1000, 16'sd1000);
      send_direction(-16'sd999, 16'sd1000, 16'sd999);
      send_direction(16'sd999, -16'sd1000, -16'sd999);
      send_direction(16'sd999, -16'sd999, 16'sd1000);
      send_direction(16'sd999, 16'sd999, -16'sd1000);
      // smallest nonzero
      send_direction(-16'sd1, 16'sd0, 16'sd0);
      send_direction(16'sd0, 16'sd0, 16'sd1);
      req_tvalid <= 1'b0;
      wait_for_drain();

      // fixed size phases plus one random phase
      for (int p = 0; p <= FIXED_PHASES; p++) begin
         if (p < FIXED_PHASES) begin
            w = PHASE_WIDTH[p];
            h = PHASE_HEIGHT[p];
         end else begin
            w = $urandom_range(1, FACE_SIZE_MAX);
            h = $urandom_range(1, FACE_SIZE_MAX);
         end
         program_face_size(REG_FACE_WIDTH, 13'(w));
         program_face_size(REG_FACE_HEIGHT, 13'(h));
         @(posedge clock);

         for (int k = 0; k < WORDS_PER_PHASE; k++) begin
            dx = random_component();
            dy = random_component();
            dz = random_component();
            // force some exact magnitude ties
            case ($urandom_range(0, 5))
               0:       dy = $urandom_range(0, 1) ? dx : -dx;
               1:       dz = $urandom_range(0, 1) ? dy : -dy;
               2:       dz = $urandom_range(0, 1) ? dx : -dx;
               default: ;
            endcase
            send_direction(dx, dy, dz);
         end
         req_tvalid <= 1'b0;
         wait_for_drain();
      end

      repeat (2 * PIPE_LATENCY) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("** cube_map_face_texel_address: PASSED **");
      end else begin
         $display("** cube_map_face_texel_address: FAILED **");
      end
      $finish;
   end

   // -------------------------------------------------------------------------
   // Receiver: random backpressure, two long hold-offs that fill the pipe
   // -------------------------------------------------------------------------
   initial begin
      int hold;
      while (reset) @(posedge clock);
      forever begin
         if (recv_count % 40 == 0) recv_burst = ($urandom_range(0, 3) == 0);
         if (recv_count == 150 || recv_count == 500) begin
            rsp_hold = 1'b1;
            hold     = 120;
         end else begin
            hold = recv_burst ? 0 : $urandom_range(0, 10);
         end
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_hold   = 1'b0;
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         board.check_result(rsp_tdata[2:0], rsp_tdata[14:3], rsp_tdata[26:15], rsp_tuser);
         recv_count++;
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: too long without a word moving on either side
   // -------------------------------------------------------------------------
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
         if (quiet >= STALL_LIMIT) begin
            $display("** cube_map_face_texel_address: FAILED **");
            $finish;
         end
      end
   end

endmodule
